FILE: rtl/apf_pkg.sv
`timescale 1ns / 1ps

package apf_pkg;

	// register map, one word per register
	typedef enum logic [1:0] {
		REG_FILTER_ORDER     = 2'd0,
		REG_FIRST_ORDER_COEF = 2'd1,
		REG_BANDWIDTH_COEF   = 2'd2,
		REG_TUNING_COEF      = 2'd3
	} reg_idx_t;

	// multiplier coefficient-side operand
	typedef enum logic [1:0] {
		A_C1 = 2'd0,
		A_C2 = 2'd1,
		A_D  = 2'd2,
		A_K  = 2'd3
	} mul_a_sel_t;

	// multiplier data-side operand
	typedef enum logic [1:0] {
		B_H1  = 2'd0,
		B_H2  = 2'd1,
		B_V   = 2'd2,
		B_OMC = 2'd3
	} mul_b_sel_t;

	// accumulator operation
	typedef enum logic [2:0] {
		ACC_HOLD  = 3'd0,
		ACC_LOAD  = 3'd1,
		ACC_ADD_P = 3'd2,
		ACC_SUB_P = 3'd3,
		ACC_ADD_S = 3'd4
	} acc_op_t;

	// accumulator operand source
	typedef enum logic [1:0] {
		SRC_X  = 2'd0,
		SRC_H1 = 2'd1,
		SRC_H2 = 2'd2,
		SRC_KH = 2'd3
	} acc_src_t;

	typedef logic [3:0] seq_step_t;

	// entry points of the program
	localparam seq_step_t STEP_START  = 4'd0;
	localparam seq_step_t STEP_SECOND = 4'd7;

	// datapath control word
	typedef struct packed {
		logic       mul_en;
		mul_a_sel_t a_sel;
		mul_b_sel_t b_sel;
		acc_op_t    acc_op;
		acc_src_t   acc_src;
		logic       wr_v;
		logic       wr_k;
		logic       wr_kh;
		logic       finish;
	} dp_ctrl_t;

	// full microcode word
	typedef struct packed {
		dp_ctrl_t  dp;
		logic      jump_order;
		seq_step_t target;
		logic      last;
	} ucode_t;

	// program store
	function automatic ucode_t ucode_rom(input seq_step_t step);
		ucode_t uc;
		uc = '0;
		unique case (step)
			// load sample, branch to the second-order program if it is selected
			4'd0: begin
				uc.dp.acc_op  = ACC_LOAD;
				uc.dp.acc_src = SRC_X;
				uc.jump_order = 1'b1;
				uc.target     = STEP_SECOND;
			end
			// first order: c * h1
			4'd1: begin
				uc.dp.mul_en = 1'b1;
				uc.dp.a_sel  = A_C1;
				uc.dp.b_sel  = B_H1;
			end
			4'd2: begin
				uc.dp.acc_op = ACC_SUB_P;
			end
			// v out, start y from h1
			4'd3: begin
				uc.dp.wr_v    = 1'b1;
				uc.dp.acc_op  = ACC_LOAD;
				uc.dp.acc_src = SRC_H1;
			end
			4'd4: begin
				uc.dp.mul_en = 1'b1;
				uc.dp.a_sel  = A_C1;
				uc.dp.b_sel  = B_V;
			end
			4'd5: begin
				uc.dp.acc_op = ACC_ADD_P;
			end
			4'd6: begin
				uc.dp.finish = 1'b1;
				uc.last      = 1'b1;
			end
			// second order: k = d * (1 - c)
			4'd7: begin
				uc.dp.mul_en = 1'b1;
				uc.dp.a_sel  = A_D;
				uc.dp.b_sel  = B_OMC;
			end
			4'd8: begin
				uc.dp.wr_k = 1'b1;
			end
			4'd9: begin
				uc.dp.mul_en = 1'b1;
				uc.dp.a_sel  = A_K;
				uc.dp.b_sel  = B_H1;
			end
			// subtract k*h1 and keep it, launch c*h2
			4'd10: begin
				uc.dp.mul_en = 1'b1;
				uc.dp.a_sel  = A_C2;
				uc.dp.b_sel  = B_H2;
				uc.dp.acc_op = ACC_SUB_P;
				uc.dp.wr_kh  = 1'b1;
			end
			4'd11: begin
				uc.dp.acc_op = ACC_ADD_P;
			end
			// v out, start y from k*h1
			4'd12: begin
				uc.dp.wr_v    = 1'b1;
				uc.dp.acc_op  = ACC_LOAD;
				uc.dp.acc_src = SRC_KH;
			end
			4'd13: begin
				uc.dp.mul_en  = 1'b1;
				uc.dp.a_sel   = A_C2;
				uc.dp.b_sel   = B_V;
				uc.dp.acc_op  = ACC_ADD_S;
				uc.dp.acc_src = SRC_H2;
			end
			4'd14: begin
				uc.dp.acc_op = ACC_SUB_P;
			end
			4'd15: begin
				uc.dp.finish = 1'b1;
				uc.last      = 1'b1;
			end
			default: begin
				uc = '0;
			end
		endcase
		return uc;
	endfunction

endpackage

FILE: rtl/allpass_filter_first_second_order_unit.sv
`timescale 1ns / 1ps
// a request runs the first-order or the second-order microcode program on the one shared multiplier
// a new request is taken only after the running program ends; the program waits at its
//   last step while the previous result is still blocked in the output register
// a finished result waits in the output register; the next request is taken meanwhile
// reset: registers zero, history zero, first order selected, no result pending

module allpass_filter_first_second_order_unit #(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           clear_history,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [3:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam int CW = COEF_FRAC_BITS + 2;

	logic                 filter_order_q;
	logic signed [CW-1:0] first_order_coef_q;
	logic signed [CW-1:0] bandwidth_coef_q;
	logic signed [CW-1:0] tuning_coef_q;
	logic                 out_valid_q;

	logic                 cfg_wr;
	apf_pkg::reg_idx_t    cfg_idx;
	logic                 in_accept;
	logic                 out_block;
	logic                 busy;
	apf_pkg::dp_ctrl_t    ctrl;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = apf_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_order_q     <= 1'b0;
			first_order_coef_q <= '0;
			bandwidth_coef_q   <= '0;
			tuning_coef_q      <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				apf_pkg::REG_FILTER_ORDER:     filter_order_q     <= pwdata[0];
				apf_pkg::REG_FIRST_ORDER_COEF: first_order_coef_q <= pwdata[CW-1:0];
				apf_pkg::REG_BANDWIDTH_COEF:   bandwidth_coef_q   <= pwdata[CW-1:0];
				apf_pkg::REG_TUNING_COEF:      tuning_coef_q      <= pwdata[CW-1:0];
				default:                       filter_order_q     <= filter_order_q;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_idx)
			apf_pkg::REG_FILTER_ORDER:
				prdata = {31'd0, filter_order_q};
			apf_pkg::REG_FIRST_ORDER_COEF:
				prdata = {{(32 - CW){first_order_coef_q[CW-1]}}, first_order_coef_q};
			apf_pkg::REG_BANDWIDTH_COEF:
				prdata = {{(32 - CW){bandwidth_coef_q[CW-1]}}, bandwidth_coef_q};
			apf_pkg::REG_TUNING_COEF:
				prdata = {{(32 - CW){tuning_coef_q[CW-1]}}, tuning_coef_q};
			default:
				prdata = '0;
		endcase
	end

	// request handshake
	assign in_stall  = busy;
	assign in_accept = in_valid && !busy;
	assign out_block = out_valid_q && out_stall;

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	apf_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_accept),
		.order     (filter_order_q),
		.out_block (out_block),
		.busy      (busy),
		.ctrl      (ctrl)
	);

	apf_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.load_x     (in_accept),
		.clear      (in_accept && clear_history),
		.sample_in  (sample_in),
		.coef_c1    (first_order_coef_q),
		.coef_c2    (bandwidth_coef_q),
		.coef_d     (tuning_coef_q),
		.sample_out (sample_out)
	);

endmodule

FILE: rtl/apf_sequencer.sv
`timescale 1ns / 1ps

module apf_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              order,
	input  logic              out_block,
	output logic              busy,
	output apf_pkg::dp_ctrl_t ctrl
);

	apf_pkg::seq_step_t step_q;
	logic               busy_q;
	apf_pkg::ucode_t    uc;
	logic               hold;

	// fetch the current control word
	assign uc   = apf_pkg::ucode_rom(step_q);
	assign hold = uc.dp.finish && out_block;
	assign busy = busy_q;

	// only issue work while running and not waiting on the result register
	always_comb begin
		ctrl = '0;
		if (busy_q && !hold) begin
			ctrl = uc.dp;
		end
	end

	// step counter with conditional jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= apf_pkg::STEP_START;
			busy_q <= 1'b0;
		end else if (start) begin
			step_q <= apf_pkg::STEP_START;
			busy_q <= 1'b1;
		end else if (busy_q && !hold) begin
			if (uc.last) begin
				busy_q <= 1'b0;
			end else if (uc.jump_order && order) begin
				step_q <= uc.target;
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

endmodule

FILE: rtl/apf_datapath.sv
`timescale 1ns / 1ps

module apf_datapath #(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  apf_pkg::dp_ctrl_t              ctrl,
	input  logic                           load_x,
	input  logic                           clear,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic signed [COEF_FRAC_BITS+1:0] coef_c1,
	input  logic signed [COEF_FRAC_BITS+1:0] coef_c2,
	input  logic signed [COEF_FRAC_BITS+1:0] coef_d,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int CF  = COEF_FRAC_BITS;
	localparam int CW  = CF + 2;
	localparam int HW  = SW + 2;
	localparam int MA  = CW + 3;
	localparam int MB  = (HW > CW + 1) ? HW : CW + 1;
	localparam int PW  = MA + MB;
	localparam int RNW = PW + 1 - CF;
	localparam int AW  = RNW + 2;

	localparam logic signed [CW:0]   COEF_ONE = (CW + 1)'(2 ** CF);
	localparam logic signed [PW:0]   HALF_LSB = (PW + 1)'(2 ** (CF - 1));
	localparam logic signed [HW-1:0] HIST_MAX = {1'b0, {(HW - 1){1'b1}}};
	localparam logic signed [HW-1:0] HIST_MIN = {1'b1, {(HW - 1){1'b0}}};
	localparam logic signed [SW-1:0] SMP_MAX  = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] SMP_MIN  = {1'b1, {(SW - 1){1'b0}}};

	logic signed [SW-1:0]  x_q;
	logic signed [HW-1:0]  h1_q;
	logic signed [HW-1:0]  h2_q;
	logic signed [HW-1:0]  v_q;
	logic signed [MA-1:0]  k_q;
	logic signed [RNW-1:0] kh_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [AW-1:0]  acc_q;
	logic signed [SW-1:0]  sample_q;

	logic signed [CW:0]    one_minus_c;
	logic signed [MA-1:0]  a_op;
	logic signed [MB-1:0]  b_op;
	logic signed [PW-1:0]  prod;
	logic signed [PW:0]    prod_half;
	logic signed [RNW-1:0] prod_rnd;
	logic signed [AW-1:0]  prod_ext;
	logic signed [AW-1:0]  src_ext;
	logic signed [HW-1:0]  v_sat;
	logic signed [SW-1:0]  y_sat;
	logic                  hist_ovf;
	logic                  smp_ovf;

	// 1 - c for the tuning product
	assign one_minus_c = COEF_ONE - {coef_c2[CW-1], coef_c2};

	// coefficient operand select
	always_comb begin
		case (ctrl.a_sel)
			apf_pkg::A_C1: a_op = {{(MA - CW){coef_c1[CW-1]}}, coef_c1};
			apf_pkg::A_C2: a_op = {{(MA - CW){coef_c2[CW-1]}}, coef_c2};
			apf_pkg::A_D:  a_op = {{(MA - CW){coef_d[CW-1]}}, coef_d};
			apf_pkg::A_K:  a_op = k_q;
			default:       a_op = k_q;
		endcase
	end

	// data operand select, sign-extended to the multiplier width
	always_comb begin
		case (ctrl.b_sel)
			apf_pkg::B_H1:  b_op = MB'(h1_q);
			apf_pkg::B_H2:  b_op = MB'(h2_q);
			apf_pkg::B_V:   b_op = MB'(v_q);
			apf_pkg::B_OMC: b_op = MB'(one_minus_c);
			default:        b_op = MB'(h1_q);
		endcase
	end

	// shared multiplier, registered
	assign prod = a_op * b_op;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= prod;
		end
	end

	// round half up to the sample grid
	assign prod_half = {prod_q[PW-1], prod_q} + HALF_LSB;
	assign prod_rnd  = prod_half[PW:CF];
	assign prod_ext  = {{(AW - RNW){prod_rnd[RNW-1]}}, prod_rnd};

	// accumulator load source
	always_comb begin
		case (ctrl.acc_src)
			apf_pkg::SRC_X:  src_ext = {{(AW - SW){x_q[SW-1]}}, x_q};
			apf_pkg::SRC_H1: src_ext = {{(AW - HW){h1_q[HW-1]}}, h1_q};
			apf_pkg::SRC_H2: src_ext = {{(AW - HW){h2_q[HW-1]}}, h2_q};
			apf_pkg::SRC_KH: src_ext = {{(AW - RNW){kh_q[RNW-1]}}, kh_q};
			default:         src_ext = {{(AW - SW){x_q[SW-1]}}, x_q};
		endcase
	end

	// saturation to history and sample range
	assign hist_ovf = !((&acc_q[AW-1:HW-1]) || !(|acc_q[AW-1:HW-1]));
	assign smp_ovf  = !((&acc_q[AW-1:SW-1]) || !(|acc_q[AW-1:SW-1]));
	assign v_sat    = hist_ovf ? (acc_q[AW-1] ? HIST_MIN : HIST_MAX) : acc_q[HW-1:0];
	assign y_sat    = smp_ovf ? (acc_q[AW-1] ? SMP_MIN : SMP_MAX) : acc_q[SW-1:0];

	// accumulator
	always_ff @(posedge clk) begin
		case (ctrl.acc_op)
			apf_pkg::ACC_LOAD:  acc_q <= src_ext;
			apf_pkg::ACC_ADD_P: acc_q <= acc_q + prod_ext;
			apf_pkg::ACC_SUB_P: acc_q <= acc_q - prod_ext;
			apf_pkg::ACC_ADD_S: acc_q <= acc_q + src_ext;
			default:            acc_q <= acc_q;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		if (load_x) begin
			x_q <= sample_in;
		end
		if (ctrl.wr_v) begin
			v_q <= v_sat;
		end
		if (ctrl.wr_k) begin
			k_q <= prod_rnd[MA-1:0];
		end
		if (ctrl.wr_kh) begin
			kh_q <= prod_rnd;
		end
		if (ctrl.finish) begin
			sample_q <= y_sat;
		end
	end

	// filter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_q <= '0;
			h2_q <= '0;
		end else if (clear) begin
			h1_q <= '0;
			h2_q <= '0;
		end else if (ctrl.finish) begin
			h2_q <= h1_q;
			h1_q <= v_q;
		end
	end

	assign sample_out = sample_q;

endmodule
